FILE: src/aeg_pkg.sv
package aeg_pkg;

    // Field widths fixed by the register map and the result format
    localparam int DUR_W     = 24;
    localparam int LVL_W     = 16;
    localparam int ENV_W     = 16;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Sum of four durations needs two more bits than one duration
    localparam int BOUND_W = DUR_W + 2;

    // Ramp numerator is elapsed time times a level difference
    localparam int NUM_W = DUR_W + LVL_W;

    // Quotient never exceeds unity, so 16 bits cover it
    localparam int QUO_W = 16;

    // Q1.15 scaling
    localparam int          FRAC_W = 15;
    localparam logic [15:0] UNITY  = 16'd32768;

    // Envelope phase codes
    localparam logic [PHASE_W-1:0] PH_SILENT  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;

    // Register reset values
    localparam logic [DUR_W-1:0] RST_ATTACK  = 24'd6554;
    localparam logic [DUR_W-1:0] RST_DECAY   = 24'd6554;
    localparam logic [DUR_W-1:0] RST_HOLD    = 24'd45875;
    localparam logic [LVL_W-1:0] RST_SUSTAIN = 16'd16384;
    localparam logic [DUR_W-1:0] RST_RELEASE = 24'd6554;

endpackage

FILE: src/aeg_if.sv
interface aeg_in_if #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [TIME_BITS-1:0]          time_now;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output time_now, output sample_in, input ready);
    modport sink   (input valid, input time_now, input sample_in, output ready);
endinterface

interface aeg_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [15:0]                   envelope_level;
    logic [2:0]                    phase;

    modport source (output valid, output sample_out, output envelope_level,
                    output phase, input ready);
    modport sink   (input valid, input sample_out, input envelope_level,
                    input phase, output ready);
endinterface

FILE: src/aeg_div_pipe.sv
module aeg_div_pipe #(
    parameter int TAG_W = 35
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [aeg_pkg::NUM_W-1:0]   num,
    input  logic [aeg_pkg::DUR_W-1:0]   den,
    input  logic [TAG_W-1:0]            tag_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [aeg_pkg::QUO_W-1:0]   quo,
    output logic [TAG_W-1:0]            tag_out
);
    import aeg_pkg::*;

    localparam int STAGES = QUO_W;

    logic [NUM_W-1:0] rem_reg   [STAGES];
    logic [QUO_W-1:0] quo_reg   [STAGES];
    logic [DUR_W-1:0] den_reg   [STAGES];
    logic [TAG_W-1:0] tag_reg   [STAGES];
    logic             valid_reg [STAGES];

    logic [NUM_W-1:0] rem_src   [STAGES];
    logic [QUO_W-1:0] quo_src   [STAGES];
    logic [DUR_W-1:0] den_src   [STAGES];
    logic [TAG_W-1:0] tag_src   [STAGES];
    logic             valid_src [STAGES];
    logic [NUM_W-1:0] rem_next  [STAGES];
    logic [QUO_W-1:0] quo_next  [STAGES];
    logic             stage_en  [STAGES];

    // Advance a stage when it is empty or the next one moves
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready = stage_en[0];

    // Route each stage's source: the input port or the previous stage
    always_comb
    begin
        rem_src[0]   = num;
        quo_src[0]   = '0;
        den_src[0]   = den;
        tag_src[0]   = tag_in;
        valid_src[0] = in_valid;
        for (int i = 1; i < STAGES; i++)
        begin
            rem_src[i]   = rem_reg[i-1];
            quo_src[i]   = quo_reg[i-1];
            den_src[i]   = den_reg[i-1];
            tag_src[i]   = tag_reg[i-1];
            valid_src[i] = valid_reg[i-1];
        end
    end

    // One restoring step per stage, most significant quotient bit first
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            logic [NUM_W-1:0] trial;
            trial = NUM_W'(den_src[i]) << (STAGES - 1 - i);
            rem_next[i] = rem_src[i];
            quo_next[i] = quo_src[i];
            if (rem_src[i] >= trial)
            begin
                rem_next[i] = rem_src[i] - trial;
                quo_next[i][STAGES-1-i] = 1'b1;
            end
        end
    end

    // Move valid bits along the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_src[i];
                end
            end
        end
    end

    // Load payload where the stage advances
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (stage_en[i])
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_src[i];
                tag_reg[i] <= tag_src[i];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign tag_out   = tag_reg[STAGES-1];

    // Ramp numerators never exceed unity times the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] && den_reg[STAGES-1] != '0
        |-> NUM_W'(rem_reg[STAGES-1]) < NUM_W'(den_reg[STAGES-1]))
    else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] && den_reg[STAGES-1] != '0
        |-> quo_reg[STAGES-1] <= UNITY)
    else $error("divider quotient above unity");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
    else $error("accepted beat not held in first divider stage");

endmodule

FILE: src/adsr_envelope_gain_core.sv
// ADSR envelope gain. Each input beat carries a time since note start
// (unsigned Q16.16) and a signed Q1.15 sample; each output beat carries the
// sample scaled by the envelope, the envelope level (Q1.15, 32768 = one) and
// the phase code (0 silent, 1 attack, 2 decay, 3 sustain, 4 release). Phase
// edges are cumulative sums of the durations, each interval closed at its
// upper end; ramps divide by the phase duration and truncate. The block
// takes one beat per clock unless back-pressured, in stages: input, phase
// decode and numerator stages, a 16-stage divider that resolves one quotient
// bit per stage, then gain and output stages. Write the configuration port
// only while no beat is in flight; it has no read-back.
module adsr_envelope_gain_core #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [aeg_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [aeg_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    aeg_in_if.sink                           in_ch,
    aeg_out_if.source                        out_ch
);
    import aeg_pkg::*;

    localparam int CMP_W  = (TIME_BITS > BOUND_W) ? TIME_BITS : BOUND_W;
    localparam int TAG_W  = PHASE_W + LVL_W + SAMPLE_BITS;
    localparam int PROD_W = SAMPLE_BITS + ENV_W + 1;

    // Configuration registers
    logic [DUR_W-1:0] attack_duration_reg;
    logic [DUR_W-1:0] decay_duration_reg;
    logic [DUR_W-1:0] hold_duration_reg;
    logic [LVL_W-1:0] sustain_level_reg;
    logic [DUR_W-1:0] release_duration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_duration_reg  <= RST_ATTACK;
            decay_duration_reg   <= RST_DECAY;
            hold_duration_reg    <= RST_HOLD;
            sustain_level_reg    <= RST_SUSTAIN;
            release_duration_reg <= RST_RELEASE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ATTACK:  attack_duration_reg  <= cfg_wdata[DUR_W-1:0];
                REG_DECAY:   decay_duration_reg   <= cfg_wdata[DUR_W-1:0];
                REG_HOLD:    hold_duration_reg    <= cfg_wdata[DUR_W-1:0];
                REG_SUSTAIN: sustain_level_reg    <= cfg_wdata[LVL_W-1:0];
                REG_RELEASE: release_duration_reg <= cfg_wdata[DUR_W-1:0];
                default:     ;
            endcase
        end
    end

    // Pipeline stage registers
    logic                          s1_valid_reg;
    logic [TIME_BITS-1:0]          s1_time_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;

    logic                          s2_valid_reg;
    logic [PHASE_W-1:0]            s2_phase_reg;
    logic [DUR_W-1:0]              s2_elapsed_reg;
    logic [DUR_W-1:0]              s2_dur_reg;
    logic [LVL_W-1:0]              s2_diff_reg;
    logic [LVL_W-1:0]              s2_lvl_reg;
    logic signed [SAMPLE_BITS-1:0] s2_sample_reg;

    logic                          s3_valid_reg;
    logic [NUM_W-1:0]              s3_num_reg;
    logic [DUR_W-1:0]              s3_dur_reg;
    logic [TAG_W-1:0]              s3_tag_reg;

    logic                          s4_valid_reg;
    logic signed [PROD_W-1:0]      s4_prod_reg;
    logic [ENV_W-1:0]              s4_env_reg;
    logic [PHASE_W-1:0]            s4_phase_reg;

    logic                          s5_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s5_sample_reg;
    logic [ENV_W-1:0]              s5_env_reg;
    logic [PHASE_W-1:0]            s5_phase_reg;

    // Stage enables, back to front
    logic en1, en2, en3, en4, en5;
    logic div_in_ready;
    logic div_out_valid;
    logic [QUO_W-1:0] div_quo;
    logic [TAG_W-1:0] div_tag;

    assign en5 = !s5_valid_reg || out_ch.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || div_in_ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign in_ch.ready = en1;

    // Decode the phase from cumulative edges and set up the ramp operands
    logic [PHASE_W-1:0] phase_next;
    logic [DUR_W-1:0]   elapsed_next;
    logic [DUR_W-1:0]   dur_next;
    logic [LVL_W-1:0]   diff_next;
    logic [LVL_W-1:0]   lvl_sat;

    always_comb
    begin
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] edge_a;
        logic [CMP_W-1:0] edge_d;
        logic [CMP_W-1:0] edge_s;
        logic [CMP_W-1:0] edge_r;
        t      = CMP_W'(s1_time_reg);
        edge_a = CMP_W'(attack_duration_reg);
        edge_d = edge_a + CMP_W'(decay_duration_reg);
        edge_s = edge_d + CMP_W'(hold_duration_reg);
        edge_r = edge_s + CMP_W'(release_duration_reg);
        lvl_sat = (sustain_level_reg > UNITY) ? UNITY : sustain_level_reg;

        phase_next   = PH_SILENT;
        elapsed_next = '0;
        dur_next     = '0;
        diff_next    = '0;
        if (t != '0 && t <= edge_a)
        begin
            phase_next   = PH_ATTACK;
            elapsed_next = t[DUR_W-1:0];
            dur_next     = attack_duration_reg;
            diff_next    = UNITY;
        end
        else if (t > edge_a && t <= edge_d)
        begin
            phase_next   = PH_DECAY;
            elapsed_next = DUR_W'(t - edge_a);
            dur_next     = decay_duration_reg;
            diff_next    = UNITY - lvl_sat;
        end
        else if (t > edge_d && t <= edge_s)
        begin
            phase_next   = PH_SUSTAIN;
            dur_next     = hold_duration_reg;
        end
        else if (t > edge_s && t <= edge_r)
        begin
            phase_next   = PH_RELEASE;
            elapsed_next = DUR_W'(t - edge_s);
            dur_next     = release_duration_reg;
            diff_next    = lvl_sat;
        end
    end

    // Valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_ch.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= div_out_valid;
            if (en5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_time_reg   <= in_ch.time_now;
            s1_sample_reg <= in_ch.sample_in;
        end
    end

    // Hold the decoded phase and ramp operands
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_phase_reg   <= phase_next;
            s2_elapsed_reg <= elapsed_next;
            s2_dur_reg     <= dur_next;
            s2_diff_reg    <= diff_next;
            s2_lvl_reg     <= lvl_sat;
            s2_sample_reg  <= s1_sample_reg;
        end
    end

    // Form the ramp numerator
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_num_reg <= NUM_W'(s2_elapsed_reg) * NUM_W'(s2_diff_reg);
            s3_dur_reg <= s2_dur_reg;
            s3_tag_reg <= {s2_phase_reg, s2_lvl_reg, s2_sample_reg};
        end
    end

    aeg_div_pipe #(
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .num       (s3_num_reg),
        .den       (s3_dur_reg),
        .tag_in    (s3_tag_reg),
        .out_valid (div_out_valid),
        .out_ready (en4),
        .quo       (div_quo),
        .tag_out   (div_tag)
    );

    // Pick the envelope from the phase and scale the sample
    logic [PHASE_W-1:0]            d_phase;
    logic [LVL_W-1:0]              d_lvl;
    logic signed [SAMPLE_BITS-1:0] d_sample;
    logic [ENV_W-1:0]              env_next;
    logic signed [PROD_W-1:0]      prod_next;

    assign {d_phase, d_lvl, d_sample} = div_tag;

    always_comb
    begin
        case (d_phase)
            PH_ATTACK:  env_next = div_quo;
            PH_DECAY:   env_next = UNITY - div_quo;
            PH_SUSTAIN: env_next = d_lvl;
            PH_RELEASE: env_next = d_lvl - div_quo;
            default:    env_next = '0;
        endcase
        prod_next = $signed({{(PROD_W - SAMPLE_BITS){d_sample[SAMPLE_BITS-1]}}, d_sample})
                  * $signed({{(PROD_W - ENV_W){1'b0}}, env_next});
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_prod_reg  <= prod_next;
            s4_env_reg   <= env_next;
            s4_phase_reg <= d_phase;
        end
    end

    // Scale back to Q1.15, truncating toward zero
    logic [PROD_W-1:0] prod_adj;

    assign prod_adj = s4_prod_reg
                    + (s4_prod_reg[PROD_W-1] ? PROD_W'(UNITY - 16'd1) : PROD_W'(0));

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_sample_reg <= prod_adj[SAMPLE_BITS+FRAC_W-1:FRAC_W];
            s5_env_reg    <= s4_env_reg;
            s5_phase_reg  <= s4_phase_reg;
        end
    end

    assign out_ch.valid          = s5_valid_reg;
    assign out_ch.sample_out     = s5_sample_reg;
    assign out_ch.envelope_level = s5_env_reg;
    assign out_ch.phase          = s5_phase_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && s5_phase_reg == PH_SILENT
        |-> s5_env_reg == '0 && s5_sample_reg == '0)
    else $error("silent phase with nonzero output");

    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> s5_env_reg <= UNITY)
    else $error("envelope above unity");

    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && s5_env_reg == '0 |-> s5_sample_reg == '0)
    else $error("zero gain with nonzero sample");

endmodule

FILE: tb/testbench.sv
module testbench;
    import aeg_pkg::*;

    localparam int TB_TIME_BITS   = 32;
    localparam int TB_SAMPLE_BITS = 16;
    localparam int PIPE_LATENCY   = 21;
    localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
    localparam int RESET_CYCLES   = 6;
    localparam int PROFILE_COUNT  = 10;
    localparam int BEATS_PER_PROF = 145;

    // One shaped output beat: gained sample, envelope level and phase code
    typedef struct packed {
        logic signed [TB_SAMPLE_BITS-1:0] sample;
        logic [ENV_W-1:0]                 level;
        logic [PHASE_W-1:0]               ph;
    } shaped_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    aeg_in_if #(.TIME_BITS(TB_TIME_BITS), .SAMPLE_BITS(TB_SAMPLE_BITS)) in_ch ();
    aeg_out_if #(.SAMPLE_BITS(TB_SAMPLE_BITS)) out_ch ();

    adsr_envelope_gain_core #(
        .TIME_BITS  (TB_TIME_BITS),
        .SAMPLE_BITS(TB_SAMPLE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Shadow copy of the envelope registers
    logic [DUR_W-1:0] attack_len  = RST_ATTACK;
    logic [DUR_W-1:0] decay_len   = RST_DECAY;
    logic [DUR_W-1:0] hold_len    = RST_HOLD;
    logic [LVL_W-1:0] sustain_lvl = RST_SUSTAIN;
    logic [DUR_W-1:0] release_len = RST_RELEASE;

    shaped_t pending_shaped[$];
    int      mismatches = 0;
    int      beat_count = 0;
    bit      idle_on    = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Envelope at time t and the sample scaled by it
    function automatic shaped_t shape_sample(input logic [TB_TIME_BITS-1:0] t,
                                             input logic signed [TB_SAMPLE_BITS-1:0] x);
        longint unsigned tt;
        longint unsigned lvl;
        longint unsigned a_edge;
        longint unsigned d_edge;
        longint unsigned s_edge;
        longint unsigned r_edge;
        longint unsigned env;
        longint          prod;
        shaped_t         res;
        tt     = t;
        lvl    = (sustain_lvl > UNITY) ? 64'(UNITY) : 64'(sustain_lvl);
        a_edge = attack_len;
        d_edge = a_edge + decay_len;
        s_edge = d_edge + hold_len;
        r_edge = s_edge + release_len;
        env    = 0;
        res.ph = PH_SILENT;
        if (tt > 0 && tt <= a_edge)
        begin
            res.ph = PH_ATTACK;
            env    = (tt * 64'(UNITY)) / a_edge;
        end
        else if (tt > a_edge && tt <= d_edge)
        begin
            res.ph = PH_DECAY;
            env    = 64'(UNITY) - ((tt - a_edge) * (64'(UNITY) - lvl)) / decay_len;
        end
        else if (tt > d_edge && tt <= s_edge)
        begin
            res.ph = PH_SUSTAIN;
            env    = lvl;
        end
        else if (tt > s_edge && tt <= r_edge)
        begin
            res.ph = PH_RELEASE;
            env    = lvl - ((tt - s_edge) * lvl) / release_len;
        end
        prod       = longint'(x) * longint'(env);
        res.sample = TB_SAMPLE_BITS'(prod / longint'(UNITY));
        res.level  = env[ENV_W-1:0];
        return res;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return DUR_W'($urandom_range(1, 64));
            6, 7:    return DUR_W'($urandom_range(65, 70000));
            default: return DUR_W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("beat %0d: %s mismatch, got %0d expected %0d", beat_count, what, got, want);
        mismatches++;
    endtask

    // Send one beat; called and returns at a falling edge
    task automatic send_beat(input logic [TB_TIME_BITS-1:0] t,
                             input logic signed [TB_SAMPLE_BITS-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.time_now  = t;
        in_ch.sample_in = x;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_shaped.insert(pending_shaped.size(), shape_sample(t, x));
        @(negedge clk);
    endtask

    // Hold off the sender until every expected beat is back
    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_shaped.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ATTACK:  attack_len  = data;
            REG_DECAY:   decay_len   = data;
            REG_HOLD:    hold_len    = data;
            REG_SUSTAIN: sustain_lvl = data[LVL_W-1:0];
            REG_RELEASE: release_len = data;
            default: ;
        endcase
    endtask

    task automatic set_profile(input logic [DUR_W-1:0] a, input logic [DUR_W-1:0] d,
                               input logic [DUR_W-1:0] h, input logic [CFG_DAT_W-1:0] sus,
                               input logic [DUR_W-1:0] r);
        drain_results();
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_HOLD, h);
        write_reg(REG_SUSTAIN, sus);
        write_reg(REG_RELEASE, r);
    endtask

    // Reset values: every phase edge and both sides of it
    task automatic test_reset_profile();
        longint unsigned a_edge;
        longint unsigned d_edge;
        longint unsigned s_edge;
        longint unsigned r_edge;
        a_edge = attack_len;
        d_edge = a_edge + decay_len;
        s_edge = d_edge + hold_len;
        r_edge = s_edge + release_len;
        idle_on = 1'b0;
        send_beat('0, 16'sh7FFF);
        send_beat(1, 16'sh8000);
        send_beat(TB_TIME_BITS'(a_edge), 16'sh7FFF);
        send_beat(TB_TIME_BITS'(a_edge + 1), 16'sh8000);
        send_beat(TB_TIME_BITS'(d_edge), -16'sd1);
        send_beat(TB_TIME_BITS'(d_edge + 1), 16'sd1);
        send_beat(TB_TIME_BITS'(s_edge), 16'sh7FFF);
        send_beat(TB_TIME_BITS'(s_edge + 1), 16'sh8000);
        send_beat(TB_TIME_BITS'(r_edge), 16'sh8000);
        send_beat(TB_TIME_BITS'(r_edge + 1), 16'sh7FFF);
        send_beat('1, 16'sh8000);
        send_beat(3000, 16'sd0);
    endtask

    // Empty phases are skipped
    task automatic test_zero_durations();
        set_profile('0, '0, '0, CFG_DAT_W'(UNITY), '0);
        send_beat('0, 16'sh7FFF);
        send_beat(1, 16'sh7FFF);
        send_beat('1, 16'sh8000);
        set_profile('0, 5, '0, '0, 3);
        send_beat(1, 16'sh7FFF);
        send_beat(5, 16'sh8000);
        send_beat(6, 16'sh7FFF);
        send_beat(8, 16'sh8000);
        send_beat(9, 16'sh7FFF);
    endtask

    // Sustain above one saturates; unused indexes are ignored
    task automatic test_sustain_saturation();
        set_profile(2, 2, 2, '1, 2);
        for (int i = int'(REG_RELEASE) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom()));
        send_beat(1, 16'sh7FFF);
        send_beat(3, 16'sh8000);
        send_beat(5, 16'sh7FFF);
        send_beat(7, 16'sh8000);
    endtask

    // Random envelopes with beats aimed at each phase, its edges and past release
    task automatic test_random_profiles();
        logic [CFG_DAT_W-1:0]             sus;
        logic [TB_TIME_BITS-1:0]          a_edge;
        logic [TB_TIME_BITS-1:0]          d_edge;
        logic [TB_TIME_BITS-1:0]          s_edge;
        logic [TB_TIME_BITS-1:0]          r_edge;
        logic [TB_TIME_BITS-1:0]          t;
        logic signed [TB_SAMPLE_BITS-1:0] x;
        int pick;
        for (int p = 0; p < PROFILE_COUNT; p++)
        begin
            idle_on = (p % 3) != 0;
            case ($urandom_range(0, 4))
                0:       sus = '0;
                1:       sus = CFG_DAT_W'(UNITY);
                2:       sus = CFG_DAT_W'($urandom_range(32769, 65535));
                default: sus = CFG_DAT_W'($urandom_range(0, 32767));
            endcase
            sus[CFG_DAT_W-1:LVL_W] = (CFG_DAT_W - LVL_W)'($urandom());
            if (p == 0)
                set_profile('1, '1, '1, '1, '1);
            else if (p == 1)
                set_profile(1, 1, 1, CFG_DAT_W'(UNITY), 1);
            else
                set_profile(pick_duration(), pick_duration(), pick_duration(), sus,
                            pick_duration());
            a_edge = TB_TIME_BITS'(attack_len);
            d_edge = a_edge + TB_TIME_BITS'(decay_len);
            s_edge = d_edge + TB_TIME_BITS'(hold_len);
            r_edge = s_edge + TB_TIME_BITS'(release_len);
            for (int i = 0; i < BEATS_PER_PROF; i++)
            begin
                t = $urandom();
                pick = $urandom_range(0, 9);
                case (pick)
                    0: t = '0;
                    1: if (a_edge > 0) t = $urandom_range(a_edge, 1);
                    2: if (d_edge > a_edge) t = $urandom_range(d_edge, a_edge + 1);
                    3: if (s_edge > d_edge) t = $urandom_range(s_edge, d_edge + 1);
                    4: if (r_edge > s_edge) t = $urandom_range(r_edge, s_edge + 1);
                    5:
                    begin
                        case ($urandom_range(0, 8))
                            0: t = a_edge;
                            1: t = a_edge + 1;
                            2: t = d_edge;
                            3: t = d_edge + 1;
                            4: t = s_edge;
                            5: t = s_edge + 1;
                            6: t = r_edge;
                            7: t = r_edge + 1;
                            default: t = 1;
                        endcase
                    end
                    6: ;
                    7: t = $urandom_range(r_edge + 1000, r_edge + 1);
                    default: t = $urandom_range(r_edge + 1, 0);
                endcase
                case ($urandom_range(0, 9))
                    0:       x = 16'sh7FFF;
                    1:       x = 16'sh8000;
                    2:       x = TB_SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);
                    default: x = TB_SAMPLE_BITS'($urandom());
                endcase
                send_beat(t, x);
                // Pause the sender once in mid stream until all beats return
                if (p == 3 && i == BEATS_PER_PROF / 2)
                    drain_results();
            end
        end
    endtask

    // Output side: random back pressure
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                stall_left   = pick_gap();
            end
        end
    end

    // Compare each output beat with the oldest expectation
    always @(posedge clk)
    begin : check_beat
        shaped_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_shaped.size() == 0)
                report_mismatch("unexpected beat", 0, 0);
            else
            begin
                want = pending_shaped.pop_front();
                if (out_ch.sample_out !== want.sample)
                    report_mismatch("sample_out", longint'(out_ch.sample_out),
                                    longint'($signed(want.sample)));
                if (out_ch.envelope_level !== want.level)
                    report_mismatch("envelope_level", longint'(out_ch.envelope_level),
                                    longint'(want.level));
                if (out_ch.phase !== want.ph)
                    report_mismatch("phase", longint'(out_ch.phase), longint'(want.ph));
            end
            beat_count++;
        end
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.time_now  = '0;
        in_ch.sample_in = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_profile();
        test_zero_durations();
        test_sustain_saturation();
        test_random_profiles();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_shaped.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
